// ===== src/pva_pkg.sv =====
// Package for the polyphonic voice allocator: sizes, event decoding,
// sequencer states and the structs passed between its modules. No dependencies.
`default_nettype none

package pva_pkg;

  localparam int NUM_VOICES   = 32;
  localparam int NUM_PARTIALS = 4;
  localparam int VIDX_W       = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;

  localparam int MODE_W  = 3;
  localparam int CH_W    = 4;
  localparam int KEY_W   = 7;
  localparam int VEL_W   = 7;
  localparam int VSEL_W  = 5;
  localparam int PSEL_W  = 2;
  localparam int VOUT_W  = 5;
  localparam int CNT_W   = 6;
  localparam int STAMP_W = 32;

  localparam logic [MODE_W-1:0] MODE_NOTE_ON   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_NOTE_OFF  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_ALL_OFF   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_PART_DONE = 3'd3;
  localparam logic [MODE_W-1:0] MODE_SWEEP     = 3'd4;

  typedef logic [VIDX_W-1:0] vidx_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_NOTE_ON,
    OP_NOTE_OFF,
    OP_ALL_OFF,
    OP_PART_DONE,
    OP_SWEEP
  } op_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_PDONE,
    S_COMMIT,
    S_FIN
  } state_e;

  typedef struct packed {
    logic in_ready;
    logic start;
    logic proc;
    logic pdone;
    logic commit;
    logic fin;
  } seq_ctrl_t;

  typedef struct packed {
    logic [CH_W-1:0]    channel;
    logic [KEY_W-1:0]   key;
    logic [STAMP_W-1:0] stamp;
  } voice_ent_t;

  // A note on with zero velocity behaves as a note off.
  function automatic op_e decode_op(logic [MODE_W-1:0] mode, logic [VEL_W-1:0] vel);
    op_e op;
    unique case (mode)
      MODE_NOTE_ON:   op = (vel != '0) ? OP_NOTE_ON : OP_NOTE_OFF;
      MODE_NOTE_OFF:  op = OP_NOTE_OFF;
      MODE_ALL_OFF:   op = OP_ALL_OFF;
      MODE_PART_DONE: op = OP_PART_DONE;
      MODE_SWEEP:     op = OP_SWEEP;
      default:        op = OP_NONE;
    endcase
    return op;
  endfunction

endpackage

`default_nettype wire

// ===== src/polyphonic_voice_allocator_core.sv =====
// Top level of the polyphonic voice allocator: voice status flops, counters,
// result register. Uses pva_pkg, pva_seq, pva_pick and pva_voice_ram.
//
//  Channel | Handshake               | Payload
//  --------+-------------------------+---------------------------------------------
//  input   | in_valid_i / in_ready_o | mode_i channel_i key_i velocity_i
//          |                         | part_mask_i voice_sel_i part_sel_i
//  output  | out_valid_o/out_ready_i | voice_index_o stolen_o active_count_o
//
// Note on, note off, all-notes-off and sweep events scan the voice table one
// voice per cycle; a note on passes its active voices through the shared age
// unit. Note off, all-notes-off and sweep have no commit step, and a note on
// that meets a free voice ends its scan early. The scan goes through the
// table memory's single read port. Reset clears the active and partial bits,
// the sequence counter and the voice count at once; the table memory is not
// cleared. A finished result sits in the output register while the next item
// is taken and worked on; only the final step of that item waits for the
// register.
`default_nettype none

module polyphonic_voice_allocator_core (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire logic [pva_pkg::MODE_W-1:0] mode_i,
  input  wire logic [pva_pkg::CH_W-1:0]   channel_i,
  input  wire logic [pva_pkg::KEY_W-1:0]  key_i,
  input  wire logic [pva_pkg::VEL_W-1:0]  velocity_i,
  input  wire logic [pva_pkg::NUM_PARTIALS-1:0] part_mask_i,
  input  wire logic [pva_pkg::VSEL_W-1:0] voice_sel_i,
  input  wire logic [pva_pkg::PSEL_W-1:0] part_sel_i,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output logic [pva_pkg::VOUT_W-1:0]      voice_index_o,
  output logic                            stolen_o,
  output logic [pva_pkg::CNT_W-1:0]       active_count_o
);
  import pva_pkg::*;

  // Per-voice status lives in flops so that reset clears it at once.
  logic [NUM_VOICES-1:0]                   active_q, active_d;
  logic [NUM_VOICES-1:0][NUM_PARTIALS-1:0] on_q, on_d;
  logic [NUM_VOICES-1:0][NUM_PARTIALS-1:0] rel_q, rel_d;

  logic [STAMP_W-1:0] seq_q, seq_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [CNT_W-1:0]   acc_q, acc_d;

  // The event being worked on.
  op_e                     op_q, op_in;
  logic [CH_W-1:0]         ch_q;
  logic [KEY_W-1:0]        key_q;
  logic [NUM_PARTIALS-1:0] mask_q;
  logic [PSEL_W-1:0]       psel_q;
  logic                    vsel_ok_q;

  logic               out_valid_q, out_valid_d;
  logic [VOUT_W-1:0]  voice_index_q;
  logic               stolen_q;
  logic [CNT_W-1:0]   active_count_q;

  seq_ctrl_t  ctrl;
  vidx_t      addr, idx, pick_idx;
  voice_ent_t ent, wr_ent;
  logic       reused, out_free, free_hit, pick_step, released;
  logic       act_i, ch_hit, key_hit, new_act, recount_op;
  logic [NUM_PARTIALS-1:0] on_i, rel_i;

  assign op_in      = decode_op(mode_i, velocity_i);
  assign out_free   = !out_valid_q || out_ready_i;
  assign recount_op = (op_q == OP_ALL_OFF) || (op_q == OP_SWEEP);

  pva_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .op_in_i     (op_in),
    .op_q_i      (op_q),
    .voice_sel_i (voice_sel_i),
    .free_hit_i  (free_hit),
    .out_free_i  (out_free),
    .ctrl_o      (ctrl),
    .addr_o      (addr),
    .idx_o       (idx)
  );

  assign wr_ent.channel = ch_q;
  assign wr_ent.key     = key_q;
  assign wr_ent.stamp   = seq_q;

  pva_voice_ram u_ram (
    .clk_i   (clk_i),
    .we_i    (ctrl.commit),
    .waddr_i (pick_idx),
    .wdata_i (wr_ent),
    .raddr_i (addr),
    .rdata_o (ent)
  );

  // Status of the voice whose table entry the memory presents this cycle.
  assign act_i    = active_q[idx];
  assign on_i     = on_q[idx];
  assign rel_i    = rel_q[idx];
  assign ch_hit   = (ent.channel == ch_q);
  assign key_hit  = (ent.key == key_q);
  assign released = (on_i & ~rel_i) == '0;

  // A note on stops at the first inactive voice; active voices go through
  // the age unit.
  assign free_hit  = ctrl.proc && (op_q == OP_NOTE_ON) && !act_i;
  assign pick_step = ctrl.proc && (op_q == OP_NOTE_ON) && act_i;

  pva_pick u_pick (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .clear_i    (ctrl.start),
    .free_i     (free_hit),
    .step_i     (pick_step),
    .released_i (released),
    .idx_i      (idx),
    .seq_i      (seq_q),
    .stamp_i    (ent.stamp),
    .pick_o     (pick_idx),
    .reused_o   (reused)
  );

  // Whether the scanned voice is still active once this event is applied;
  // this feeds the recount of all-notes-off and sweep.
  always_comb begin
    unique case (op_q)
      OP_ALL_OFF: new_act = act_i && !ch_hit;
      OP_SWEEP:   new_act = act_i && (on_i != '0);
      default:    new_act = act_i;
    endcase
  end

  always_comb begin
    active_d = active_q;
    on_d     = on_q;
    rel_d    = rel_q;
    seq_d    = seq_q;
    count_d  = count_q;
    acc_d    = acc_q;

    if (ctrl.start) begin
      acc_d = '0;
      if (op_in == OP_NOTE_ON) begin
        seq_d = seq_q + 1'b1;
      end
    end

    if (ctrl.proc) begin
      unique case (op_q)
        OP_NOTE_OFF: begin
          if (act_i && ch_hit && key_hit) begin
            rel_d[idx] = rel_i | on_i;
          end
        end
        OP_ALL_OFF: begin
          if (act_i && ch_hit) begin
            active_d[idx] = 1'b0;
            on_d[idx]     = '0;
            rel_d[idx]    = '0;
          end
          acc_d = acc_q + CNT_W'(new_act);
        end
        OP_SWEEP: begin
          if (act_i && (on_i == '0)) begin
            active_d[idx] = 1'b0;
          end
          acc_d = acc_q + CNT_W'(new_act);
        end
        default: ;
      endcase
    end

    // A finished partial is dropped only when it was on and released.
    if (ctrl.pdone && vsel_ok_q && act_i && on_i[psel_q] && rel_i[psel_q]) begin
      on_d[idx][psel_q]  = 1'b0;
      rel_d[idx][psel_q] = 1'b0;
    end

    if (ctrl.commit) begin
      active_d[pick_idx] = 1'b1;
      on_d[pick_idx]     = mask_q;
      rel_d[pick_idx]    = '0;
      if (!reused) begin
        count_d = count_q + 1'b1;
      end
    end

    if (ctrl.fin && recount_op) begin
      count_d = acc_q;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (ctrl.fin) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= '0;
      on_q        <= '0;
      rel_q       <= '0;
      seq_q       <= '0;
      count_q     <= '0;
      op_q        <= OP_NONE;
      out_valid_q <= 1'b0;
    end else begin
      active_q    <= active_d;
      on_q        <= on_d;
      rel_q       <= rel_d;
      seq_q       <= seq_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      if (ctrl.start) begin
        op_q <= op_in;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    if (ctrl.start) begin
      ch_q      <= channel_i;
      key_q     <= key_i;
      mask_q    <= part_mask_i;
      psel_q    <= part_sel_i;
      vsel_ok_q <= int'(voice_sel_i) < NUM_VOICES;
    end
    if (ctrl.fin) begin
      voice_index_q  <= (op_q == OP_NOTE_ON) ? VOUT_W'(pick_idx) : '0;
      stolen_q       <= (op_q == OP_NOTE_ON) && reused;
      active_count_q <= recount_op ? acc_q : count_q;
    end
  end

  assign in_ready_o     = ctrl.in_ready;
  assign out_valid_o    = out_valid_q;
  assign voice_index_o  = voice_index_q;
  assign stolen_o       = stolen_q;
  assign active_count_o = active_count_q;

`ifndef SYNTHESIS
  // Between events the running count agrees with the active bits.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.in_ready |-> (count_q == CNT_W'($countones(active_q))))
    else $error("voice count differs from the number of active voices");

  // The voice chosen by a note on is active afterwards.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.commit |=> active_q[$past(pick_idx)])
    else $error("allocated voice is not active");

  // A result appears only from the final step of an item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(ctrl.fin))
    else $error("result raised outside the final step");
`endif

endmodule

`default_nettype wire

// ===== src/pva_voice_ram.sv =====
// Voice table memory: channel, key and note-on stamp of each voice.
// One write port, one read port with registered read data. Uses pva_pkg.
`default_nettype none

module pva_voice_ram (
  input  wire logic               clk_i,
  input  wire logic               we_i,
  input  wire pva_pkg::vidx_t     waddr_i,
  input  wire pva_pkg::voice_ent_t wdata_i,
  input  wire pva_pkg::vidx_t     raddr_i,
  output pva_pkg::voice_ent_t     rdata_o
);
  import pva_pkg::*;

  voice_ent_t mem [NUM_VOICES];
  voice_ent_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== src/pva_pick.sv =====
// Shared age unit: one stamp subtract and compare per scanned voice,
// tracking the first free, oldest released and oldest voice. Uses pva_pkg.
`default_nettype none

module pva_pick (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        clear_i,
  input  wire logic                        free_i,
  input  wire logic                        step_i,
  input  wire logic                        released_i,
  input  wire pva_pkg::vidx_t              idx_i,
  input  wire logic [pva_pkg::STAMP_W-1:0] seq_i,
  input  wire logic [pva_pkg::STAMP_W-1:0] stamp_i,
  output pva_pkg::vidx_t                   pick_o,
  output logic                             reused_o
);
  import pva_pkg::*;

  logic               free_found_q, free_found_d;
  logic               rel_found_q, rel_found_d;
  vidx_t              free_idx_q, free_idx_d;
  vidx_t              lru_idx_q, lru_idx_d;
  vidx_t              rel_idx_q, rel_idx_d;
  logic [STAMP_W-1:0] lru_age_q, lru_age_d;
  logic [STAMP_W-1:0] rel_age_q, rel_age_d;
  logic [STAMP_W-1:0] age;

  // Age wraps modulo the stamp width, like the sequence counter.
  assign age = seq_i - stamp_i;

  always_comb begin
    free_found_d = free_found_q;
    rel_found_d  = rel_found_q;
    free_idx_d   = free_idx_q;
    lru_idx_d    = lru_idx_q;
    rel_idx_d    = rel_idx_q;
    lru_age_d    = lru_age_q;
    rel_age_d    = rel_age_q;
    if (clear_i) begin
      free_found_d = 1'b0;
      rel_found_d  = 1'b0;
      lru_age_d    = '0;
      rel_age_d    = '0;
    end else if (free_i) begin
      free_found_d = 1'b1;
      free_idx_d   = idx_i;
    end else if (step_i) begin
      // Ties favor the later voice, so equal ages replace the holder.
      if (age >= lru_age_q) begin
        lru_age_d = age;
        lru_idx_d = idx_i;
      end
      if (released_i && age >= rel_age_q) begin
        rel_found_d = 1'b1;
        rel_age_d   = age;
        rel_idx_d   = idx_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_found_q <= 1'b0;
      rel_found_q  <= 1'b0;
    end else begin
      free_found_q <= free_found_d;
      rel_found_q  <= rel_found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    free_idx_q <= free_idx_d;
    lru_idx_q  <= lru_idx_d;
    rel_idx_q  <= rel_idx_d;
    lru_age_q  <= lru_age_d;
    rel_age_q  <= rel_age_d;
  end

  assign pick_o   = free_found_q ? free_idx_q : (rel_found_q ? rel_idx_q : lru_idx_q);
  assign reused_o = !free_found_q;

endmodule

`default_nettype wire

// ===== src/pva_seq.sv =====
// Event sequencer: state machine, voice scan address and the index of the
// voice whose table data is presented this cycle. Uses pva_pkg.
`default_nettype none

module pva_seq (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  input  wire pva_pkg::op_e               op_in_i,
  input  wire pva_pkg::op_e               op_q_i,
  input  wire logic [pva_pkg::VSEL_W-1:0] voice_sel_i,
  input  wire logic                       free_hit_i,
  input  wire logic                       out_free_i,
  output pva_pkg::seq_ctrl_t              ctrl_o,
  output pva_pkg::vidx_t                  addr_o,
  output pva_pkg::vidx_t                  idx_o
);
  import pva_pkg::*;

  localparam vidx_t LAST_VOICE = VIDX_W'(NUM_VOICES - 1);

  state_e state_q, state_d;
  vidx_t  addr_q, addr_d;
  vidx_t  idx_q, idx_d;
  logic   v1_q;
  logic   start;

  assign start = (state_q == S_IDLE) && in_valid_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          unique case (op_in_i)
            OP_PART_DONE: state_d = S_PDONE;
            OP_NONE:      state_d = S_FIN;
            default:      state_d = S_SCAN;
          endcase
        end
      end
      S_SCAN: begin
        if (free_hit_i) begin
          state_d = S_COMMIT;
        end else if (addr_q == LAST_VOICE) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN:  state_d = (op_q_i == OP_NOTE_ON) ? S_COMMIT : S_FIN;
      S_PDONE:  state_d = S_FIN;
      S_COMMIT: state_d = S_FIN;
      S_FIN: begin
        if (out_free_i) begin
          state_d = S_IDLE;
        end
      end
      default:  state_d = S_IDLE;
    endcase
  end

  always_comb begin
    addr_d = addr_q;
    idx_d  = idx_q;
    if (start) begin
      addr_d = '0;
      idx_d  = VIDX_W'(voice_sel_i);
    end else if (state_q == S_SCAN) begin
      idx_d = addr_q;
      if (addr_q != LAST_VOICE) begin
        addr_d = addr_q + 1'b1;
      end
    end
  end

  always_comb begin
    ctrl_o.in_ready = (state_q == S_IDLE);
    ctrl_o.start    = start;
    ctrl_o.proc     = v1_q && ((state_q == S_SCAN) || (state_q == S_DRAIN));
    ctrl_o.pdone    = (state_q == S_PDONE);
    ctrl_o.commit   = (state_q == S_COMMIT);
    ctrl_o.fin      = (state_q == S_FIN) && out_free_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      v1_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      v1_q    <= (state_q == S_SCAN);
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q <= addr_d;
    idx_q  <= idx_d;
  end

  assign addr_o = addr_q;
  assign idx_o  = idx_q;

endmodule

`default_nettype wire

// ===== dv/polyphonic_voice_allocator_core_test.sv =====
// Self-checking testbench for polyphonic_voice_allocator_core: directed and random note events
// against a voice-table predictor kept in a small scoreboard class.
// Depends on pva_pkg and the allocator RTL only.

module polyphonic_voice_allocator_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import pva_pkg::*;

  localparam int CLK_PERIOD   = 10;
  localparam int RESET_CYCLES = 9;
  localparam int RANDOM_ITEMS = 1300;
  // The tail of the run is sized from the worst event, a scan of the whole table.
  localparam int TAIL_CYCLES  = 4 * (NUM_VOICES + 4);
  localparam int LIMIT_CYCLES = 400_000;
  localparam int MAX_PRINTED  = 100;
  localparam int RECENT_DEPTH = 24;
  localparam logic [MODE_W-1:0] MODE_TOP = '1;

  typedef struct packed {
    logic [MODE_W-1:0]       mode;
    logic [CH_W-1:0]         channel;
    logic [KEY_W-1:0]        key;
    logic [VEL_W-1:0]        velocity;
    logic [NUM_PARTIALS-1:0] part_mask;
    logic [VSEL_W-1:0]       voice_sel;
    logic [PSEL_W-1:0]       part_sel;
  } note_evt_t;

  typedef struct packed {
    logic [VOUT_W-1:0] voice_index;
    logic              stolen;
    logic [CNT_W-1:0]  active_count;
  } voice_res_t;

  typedef enum int {RX_ALWAYS, RX_RANDOM, RX_BURSTY} rx_style_e;

  // The scoreboard keeps its own copy of the voice table. Every accepted
  // event is applied to that table at once, and the result that the event
  // must produce is queued for the output side.
  class VoiceScoreboard;
    bit                      active[NUM_VOICES];
    logic [CH_W-1:0]         chan[NUM_VOICES];
    logic [KEY_W-1:0]        keyv[NUM_VOICES];
    logic [STAMP_W-1:0]      stamp[NUM_VOICES];
    logic [NUM_PARTIALS-1:0] part_on[NUM_VOICES];
    logic [NUM_PARTIALS-1:0] part_rel[NUM_VOICES];
    logic [STAMP_W-1:0]      seq_count;
    logic [CNT_W-1:0]        voice_count;
    voice_res_t              expected_q[$];
    int                      errors;

    function new();
      for (int i = 0; i < NUM_VOICES; i++) begin
        active[i]   = 1'b0;
        chan[i]     = '0;
        keyv[i]     = '0;
        stamp[i]    = '0;
        part_on[i]  = '0;
        part_rel[i] = '0;
      end
      seq_count   = '0;
      voice_count = '0;
      errors      = 0;
    endfunction

    function void recount();
      voice_count = '0;
      for (int i = 0; i < NUM_VOICES; i++)
        if (active[i]) voice_count++;
    endfunction

    // First free voice wins. Otherwise the oldest fully released voice, and
    // failing that the oldest voice; ties go to the higher index.
    function int choose_voice();
      int                 rel_idx;
      int                 lru_idx;
      logic [STAMP_W-1:0] rel_age;
      logic [STAMP_W-1:0] lru_age;
      logic [STAMP_W-1:0] age;
      rel_idx = -1;
      lru_idx = 0;
      rel_age = '0;
      lru_age = '0;
      for (int i = 0; i < NUM_VOICES; i++) begin
        if (!active[i]) return i;
        age = seq_count - stamp[i];
        if (age >= lru_age) begin
          lru_age = age;
          lru_idx = i;
        end
        if ((part_on[i] & ~part_rel[i]) == '0 && age >= rel_age) begin
          rel_age = age;
          rel_idx = i;
        end
      end
      return (rel_idx >= 0) ? rel_idx : lru_idx;
    endfunction

    function void note_event(note_evt_t ev);
      voice_res_t              res;
      int                      v;
      bit                      reused;
      logic [NUM_PARTIALS-1:0] bitm;
      res = '0;
      if (ev.mode == MODE_NOTE_ON && ev.velocity != '0) begin
        seq_count++;
        v = choose_voice();
        reused = active[v];
        active[v]   = 1'b1;
        stamp[v]    = seq_count;
        chan[v]     = ev.channel;
        keyv[v]     = ev.key;
        part_on[v]  = ev.part_mask;
        part_rel[v] = '0;
        if (!reused) voice_count++;
        res.voice_index = v[VOUT_W-1:0];
        res.stolen      = reused;
      end else if (ev.mode == MODE_NOTE_ON || ev.mode == MODE_NOTE_OFF) begin
        for (int i = 0; i < NUM_VOICES; i++)
          if (active[i] && chan[i] == ev.channel && keyv[i] == ev.key)
            part_rel[i] |= part_on[i];
      end else if (ev.mode == MODE_ALL_OFF) begin
        for (int i = 0; i < NUM_VOICES; i++) begin
          if (active[i] && chan[i] == ev.channel) begin
            active[i]   = 1'b0;
            part_on[i]  = '0;
            part_rel[i] = '0;
          end
        end
        recount();
      end else if (ev.mode == MODE_PART_DONE) begin
        if (int'(ev.voice_sel) < NUM_VOICES && active[ev.voice_sel]) begin
          bitm = NUM_PARTIALS'(1) << ev.part_sel;
          if ((part_on[ev.voice_sel] & bitm) != '0 && (part_rel[ev.voice_sel] & bitm) != '0) begin
            part_on[ev.voice_sel]  &= ~bitm;
            part_rel[ev.voice_sel] &= ~bitm;
          end
        end
      end else if (ev.mode == MODE_SWEEP) begin
        for (int i = 0; i < NUM_VOICES; i++)
          if (active[i] && part_on[i] == '0) active[i] = 1'b0;
        recount();
      end
      res.active_count = voice_count;
      expected_q.push_back(res);
    endfunction

    // Looks for a partial that has been released but not yet finished, so
    // that partial-done events mostly hit something real.
    function bit find_done_target(output logic [VSEL_W-1:0] vs, output logic [PSEL_W-1:0] ps);
      int v;
      int p;
      int v0;
      int p0;
      vs = '0;
      ps = '0;
      v0 = $urandom_range(0, NUM_VOICES - 1);
      p0 = $urandom_range(0, NUM_PARTIALS - 1);
      for (int i = 0; i < NUM_VOICES; i++) begin
        v = (v0 + i) % NUM_VOICES;
        if (active[v] && (part_on[v] & part_rel[v]) != '0) begin
          for (int j = 0; j < NUM_PARTIALS; j++) begin
            p = (p0 + j) % NUM_PARTIALS;
            if (part_on[v][p] && part_rel[v][p]) begin
              vs = VSEL_W'(v);
              ps = PSEL_W'(p);
              return 1'b1;
            end
          end
        end
      end
      return 1'b0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    task report_mismatch(string msg);
      errors++;
      if (errors <= MAX_PRINTED) $display("[%0t] MISMATCH: %s", $realtime, msg);
    endtask

    task check_result(voice_res_t got);
      voice_res_t exp_res;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("result idx=%0d stolen=%0d count=%0d with no item pending",
                                  got.voice_index, got.stolen, got.active_count));
        return;
      end
      exp_res = expected_q.pop_front();
      if (got.voice_index !== exp_res.voice_index)
        report_mismatch($sformatf("voice_index %0d, expected %0d",
                                  got.voice_index, exp_res.voice_index));
      if (got.stolen !== exp_res.stolen)
        report_mismatch($sformatf("stolen %0d, expected %0d", got.stolen, exp_res.stolen));
      if (got.active_count !== exp_res.active_count)
        report_mismatch($sformatf("active_count %0d, expected %0d",
                                  got.active_count, exp_res.active_count));
    endtask
  endclass

  logic                    clk_i = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic [MODE_W-1:0]       mode = '0;
  logic [CH_W-1:0]         channel = '0;
  logic [KEY_W-1:0]        key = '0;
  logic [VEL_W-1:0]        velocity = '0;
  logic [NUM_PARTIALS-1:0] part_mask = '0;
  logic [VSEL_W-1:0]       voice_sel = '0;
  logic [PSEL_W-1:0]       part_sel = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic [VOUT_W-1:0]       voice_index;
  logic                    stolen;
  logic [CNT_W-1:0]        active_count;

  VoiceScoreboard          sb = new();
  int                      cycle_count = 0;
  rx_style_e               rx_style = RX_ALWAYS;
  int                      rx_style_left = 0;
  logic [CH_W+KEY_W-1:0]   recent_notes[$];

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  polyphonic_voice_allocator_core i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .mode_i         (mode),
    .channel_i      (channel),
    .key_i          (key),
    .velocity_i     (velocity),
    .part_mask_i    (part_mask),
    .voice_sel_i    (voice_sel),
    .part_sel_i     (part_sel),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .voice_index_o  (voice_index),
    .stolen_o       (stolen),
    .active_count_o (active_count)
  );

  // The watchdog ends a hung run. It also provides the cycle count that the
  // bursty receiver pattern keys off.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // The receiver switches between always ready, coin-flip stalls and a
  // fixed duty pattern. Each style holds for a random stretch of cycles, so
  // stalls land on every phase of the block's work.
  always @(posedge clk_i) begin
    if (rx_style_left == 0) begin
      rx_style      <= rx_style_e'($urandom_range(0, 2));
      rx_style_left <= $urandom_range(20, 200);
    end else begin
      rx_style_left <= rx_style_left - 1;
    end
    case (rx_style)
      RX_ALWAYS: out_ready <= 1'b1;
      RX_RANDOM: out_ready <= 1'($urandom_range(0, 1));
      default:   out_ready <= (cycle_count % 11) > 6;
    endcase
  end

  // Results are sampled at the clock edge, using the values from before the edge.
  always @(posedge clk_i) begin
    if (rst_n && out_valid && out_ready)
      sb.check_result('{voice_index: voice_index, stolen: stolen, active_count: active_count});
  end

  function automatic note_evt_t make_evt(logic [MODE_W-1:0] m, int ch, int k, int vel,
                                         int mask, int vs, int ps);
    note_evt_t ev;
    ev.mode      = m;
    ev.channel   = CH_W'(ch);
    ev.key       = KEY_W'(k);
    ev.velocity  = VEL_W'(vel);
    ev.part_mask = NUM_PARTIALS'(mask);
    ev.voice_sel = VSEL_W'(vs);
    ev.part_sel  = PSEL_W'(ps);
    return ev;
  endfunction

  // Holds the item on the port until it is taken, then updates the
  // scoreboard. Valid is left high so that the next item can follow right
  // away without a bubble.
  task automatic send_event(note_evt_t ev);
    mode      <= ev.mode;
    channel   <= ev.channel;
    key       <= ev.key;
    velocity  <= ev.velocity;
    part_mask <= ev.part_mask;
    voice_sel <= ev.voice_sel;
    part_sel  <= ev.part_sel;
    in_valid  <= 1'b1;
    do @(posedge clk_i); while (!in_ready);
    sb.note_event(ev);
    if (ev.mode == MODE_NOTE_ON && ev.velocity != '0) begin
      recent_notes.push_back({ev.channel, ev.key});
      if (recent_notes.size() > RECENT_DEPTH) void'(recent_notes.pop_front());
    end
  endtask

  task automatic pause_sender(int cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  task automatic wait_all_results();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // Most traffic sits on a few channels and a small key range, so that note
  // offs, partial-done events and sweeps find voices to act on and the table
  // fills up enough to force voice stealing. A share of random noise keeps
  // every field bit moving.
  function automatic note_evt_t make_random_event();
    note_evt_t             ev;
    int                    pick;
    logic [CH_W+KEY_W-1:0] note;
    logic [VSEL_W-1:0]     vs;
    logic [PSEL_W-1:0]     ps;
    ev = make_evt(MODE_NOTE_ON, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    pick = $urandom_range(0, 99);
    if (pick < 42) begin
      ev.mode      = MODE_NOTE_ON;
      ev.channel   = ($urandom_range(0, 3) == 0) ? CH_W'($urandom) : CH_W'($urandom_range(0, 3));
      ev.key       = ($urandom_range(0, 3) == 0) ? KEY_W'($urandom) : KEY_W'($urandom_range(60, 67));
      ev.velocity  = VEL_W'($urandom_range(1, 127));
      ev.part_mask = ($urandom_range(0, 7) == 0) ? '0 : NUM_PARTIALS'($urandom_range(1, 15));
    end else if (pick < 60) begin
      // A note off, sometimes written as a note on with zero velocity.
      if (recent_notes.size() != 0 && $urandom_range(0, 3) != 0) begin
        note = recent_notes[$urandom_range(0, recent_notes.size() - 1)];
        {ev.channel, ev.key} = note;
      end
      if ($urandom_range(0, 1) == 0) begin
        ev.mode = MODE_NOTE_OFF;
      end else begin
        ev.mode     = MODE_NOTE_ON;
        ev.velocity = '0;
      end
    end else if (pick < 84) begin
      ev.mode = MODE_PART_DONE;
      if ($urandom_range(0, 4) != 0 && sb.find_done_target(vs, ps)) begin
        ev.voice_sel = vs;
        ev.part_sel  = ps;
      end
    end else if (pick < 90) begin
      ev.mode = MODE_SWEEP;
    end else if (pick < 93) begin
      ev.mode = MODE_ALL_OFF;
      if ($urandom_range(0, 3) != 0) ev.channel = CH_W'($urandom_range(0, 3));
    end else if (pick < 96) begin
      ev.mode = MODE_W'($urandom_range(int'(MODE_SWEEP) + 1, int'(MODE_TOP)));
    end else begin
      ev.mode = MODE_W'($urandom_range(0, int'(MODE_SWEEP)));
    end
    return ev;
  endfunction

  initial begin
    note_evt_t ev;
    int        useful_sent;
    int        burst_left;
    int        gap;
    bit        drained_mid;

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    // Directed part. Voice 0 has full extremes. Voice 1 has an empty mask.
    // Voice 2 is ended by a note on with zero velocity.
    send_event(make_evt(MODE_NOTE_ON, 0, 0, 127, 'hF, 0, 0));
    send_event(make_evt(MODE_NOTE_ON, 15, 127, 1, 'h0, 31, 3));
    send_event(make_evt(MODE_NOTE_ON, 5, 60, 64, 'h5, 0, 0));
    send_event(make_evt(MODE_NOTE_ON, 5, 60, 0, 'hA, 17, 1));
    send_event(make_evt(MODE_NOTE_OFF, 0, 0, 0, 'h0, 0, 0));
    send_event(make_evt(MODE_NOTE_OFF, 9, 33, 127, 'hF, 0, 0));
    // Partial done: two real completions on voice 0, then a partial that is
    // not on, an inactive voice, and a real completion on voice 2.
    send_event(make_evt(MODE_PART_DONE, 0, 0, 0, 'h0, 0, 0));
    send_event(make_evt(MODE_PART_DONE, 0, 0, 0, 'h0, 0, 3));
    send_event(make_evt(MODE_PART_DONE, 0, 0, 0, 'h0, 2, 1));
    send_event(make_evt(MODE_PART_DONE, 0, 0, 0, 'h0, 31, 2));
    send_event(make_evt(MODE_PART_DONE, 0, 0, 0, 'h0, 2, 0));
    // A sweep frees only the empty-mask voice.
    send_event(make_evt(MODE_SWEEP, 0, 0, 0, 'h0, 0, 0));
    send_event(make_evt(MODE_PART_DONE, 0, 0, 0, 'h0, 2, 2));
    send_event(make_evt(MODE_NOTE_ON, 5, 61, 100, 'h8, 0, 0));
    send_event(make_evt(MODE_ALL_OFF, 5, 0, 0, 'h0, 0, 0));
    send_event(make_evt(MODE_SWEEP, 15, 127, 127, 'hF, 31, 3));
    // Unused mode codes must leave the table alone and only report the count.
    send_event(make_evt(MODE_W'(MODE_SWEEP + 1), 3, 3, 3, 'h3, 3, 3));
    send_event(make_evt(MODE_TOP, 15, 127, 127, 'hF, 31, 3));
    send_event(make_evt(MODE_NOTE_ON, 15, 127, 127, 'hF, 0, 0));
    send_event(make_evt(MODE_ALL_OFF, 0, 0, 0, 'h0, 0, 0));
    wait_all_results();

    // Random part. The sender runs in bursts with random gaps, and some long
    // bursts have no gap at all.
    useful_sent = 0;
    burst_left  = 0;
    drained_mid = 1'b0;
    while (useful_sent < RANDOM_ITEMS) begin
      if (!drained_mid && useful_sent >= RANDOM_ITEMS / 2) begin
        wait_all_results();
        drained_mid = 1'b1;
      end
      if (burst_left == 0) begin
        burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 150)
                                                 : $urandom_range(1, 24);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        if (gap > 0) pause_sender(gap);
      end
      ev = make_random_event();
      send_event(ev);
      burst_left--;
      if (ev.mode <= MODE_SWEEP) useful_sent++;
    end

    wait_all_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/pva_pkg.sv
src/pva_voice_ram.sv
src/pva_pick.sv
src/pva_seq.sv
src/polyphonic_voice_allocator_core.sv
dv/polyphonic_voice_allocator_core_test.sv
